### src/rhcb_pkg.sv
// ----------------------------------------------------------------------------
// rhcb_pkg
// Shared constants, types and hash tables of the chunk boundary finder.
// ----------------------------------------------------------------------------
package rhcb_pkg;

    // Bytes held in the rolling window (range 2 to 32)
    localparam int WINDOW_BYTES = 16;

    localparam int HASH_W = 40;

    localparam logic [HASH_W-1:0] HASH_MULT     = 40'd153191;
    localparam logic [HASH_W-1:0] HASH_MASK     = 40'hff_ffff_ffff;
    localparam logic [63:0]       TAP_POLY      = 64'hbfe6_b8a5_bf37_8d83;
    localparam logic [31:0]       TAP_POLY_LO   = TAP_POLY[31:0];
    localparam logic [31:0]       HASH_MULT_32  = HASH_MULT[31:0];

    // Configuration register indexes
    localparam logic [1:0] REG_MIN_CHUNK     = 2'd0;
    localparam logic [1:0] REG_MAX_CHUNK     = 2'd1;
    localparam logic [1:0] REG_BOUNDARY_BITS = 2'd2;
    localparam logic [1:0] REG_STREAM_LENGTH = 2'd3;

    // Configuration reset values
    localparam logic [15:0] MIN_CHUNK_RST     = 16'd2048;
    localparam logic [15:0] MAX_CHUNK_RST     = 16'd8192;
    localparam logic [4:0]  BOUNDARY_BITS_RST = 5'd12;
    localparam logic [31:0] STREAM_LENGTH_RST = 32'hffff_ffff;

    typedef logic [255:0][HASH_W-1:0] rhcb_table_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        chunk_end;
        logic [15:0] chunk_length;
    } rhcb_result_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [7:0]        newest;
        logic [7:0]        oldest;
        logic [4:0]        boundary_bits;
    } rhcb_hash_req_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash_next;
        logic              content_hit;
    } rhcb_hash_rsp_t;

    // leaving[b] = b * HASH_MULT^WINDOW_BYTES, modulo 2^40
    function automatic rhcb_table_t build_leaving_table();
        rhcb_table_t       t;
        logic [HASH_W-1:0] pw;
        pw = 40'd1;
        for (int k = 0; k < WINDOW_BYTES; k++)
        begin
            pw = pw * HASH_MULT;
        end
        for (int b = 0; b < 256; b++)
        begin
            t[b] = HASH_W'(b) * pw;
        end
        return t;
    endfunction

    // poly[b] = 1 + sum over set tap bits of (HASH_MULT^i * b) modulo 2^32
    function automatic rhcb_table_t build_polynomial_table();
        rhcb_table_t       t;
        logic [HASH_W-1:0] acc;
        logic [31:0]       p32;
        logic [31:0]       term;
        for (int b = 0; b < 256; b++)
        begin
            acc = 40'd1;
            p32 = 32'd1;
            for (int k = 0; k < WINDOW_BYTES; k++)
            begin
                term = p32 * 32'(b);
                if (TAP_POLY_LO[k])
                begin
                    acc = acc + {8'd0, term};
                end
                p32 = p32 * HASH_MULT_32;
            end
            t[b] = acc & HASH_MASK;
        end
        return t;
    endfunction

    localparam rhcb_table_t LEAVING_TABLE    = build_leaving_table();
    localparam rhcb_table_t POLYNOMIAL_TABLE = build_polynomial_table();

endpackage

### src/rhcb_if.sv
// ----------------------------------------------------------------------------
// rhcb_in_if / rhcb_out_if
// Valid/ready channels carrying stream bytes in and tagged bytes out.
// ----------------------------------------------------------------------------
interface rhcb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rhcb_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        chunk_end;
    logic [15:0] chunk_length;

    modport source (output valid, output out_byte, output chunk_end,
                    output chunk_length, input ready);
    modport sink   (input valid, input out_byte, input chunk_end,
                    input chunk_length, output ready);
endinterface

### src/rolling_hash_chunk_boundary.sv
// ----------------------------------------------------------------------------
// rolling_hash_chunk_boundary
// Content-defined chunking: passes bytes through and flags chunk ends.
// ----------------------------------------------------------------------------
// The block takes one byte request per cycle while input ready is high and
// returns it unchanged, tagged with the running chunk length and a chunk-end
// flag. Throughput is one byte per clock while the buffer has room; a byte's
// result is computed combinationally and registered in the output buffer.
// The rate is set by the rolling hash loop: the 40-bit multiply by the hash
// constant, the add of the newest window byte, the subtract of the leaving
// table entry and the low-bit test form one combinational path, since the
// clear at a chunk end feeds the next byte's hash. A two-entry output buffer
// keeps the input ready while one finished result waits and drops ready while
// both entries are full, so a downstream stall reaches the source only then.
// Chunk rules:
//  - the first window of each chunk only fills the byte window;
//  - after that, a zero in the low boundary_bits bits of the fingerprint ends
//    the chunk once its length has reached min_chunk;
//  - a chunk always ends at max_chunk (zero acts like one);
//  - the byte that brings the stream count to stream_length ends a chunk and
//    starts a new stream (zero acts as 2^32).
// Write configuration only while no byte is in flight. Register indexes:
// 0 min_chunk, 1 max_chunk, 2 boundary_bits, 3 stream_length.
// ----------------------------------------------------------------------------
module rolling_hash_chunk_boundary
    import rhcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    rhcb_in_if.sink           data_in,
    rhcb_out_if.source        data_out
);

    logic         accept;
    logic         can_push;
    rhcb_result_t result;
    rhcb_result_t pop_data;

    // Take a request whenever the buffer has room
    assign data_in.ready = can_push;
    assign accept        = data_in.valid && can_push;

    rhcb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (data_in.data_byte),
        .result    (result)
    );

    // Hold results here until the sink takes them
    rhcb_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .can_push  (can_push),
        .pop_valid (data_out.valid),
        .pop_ready (data_out.ready),
        .pop_data  (pop_data)
    );

    assign data_out.out_byte     = pop_data.out_byte;
    assign data_out.chunk_end    = pop_data.chunk_end;
    assign data_out.chunk_length = pop_data.chunk_length;

endmodule

### src/rhcb_hash.sv
// ----------------------------------------------------------------------------
// rhcb_hash
// Rolling hash update and low-bit boundary test for one byte.
// ----------------------------------------------------------------------------
module rhcb_hash
    import rhcb_pkg::*;
(
    input  rhcb_hash_req_t req,
    output rhcb_hash_rsp_t rsp
);

    logic [HASH_W-1:0] product;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] fingerprint;
    logic [HASH_W-1:0] mask;

    always_comb
    begin
        product     = req.hash * HASH_MULT;
        hash_next   = product + {32'd0, req.newest} - LEAVING_TABLE[req.oldest];
        fingerprint = hash_next ^ POLYNOMIAL_TABLE[req.oldest];
        mask        = (HASH_W'(1) << req.boundary_bits) - HASH_W'(1);
        rsp.hash_next   = hash_next;
        rsp.content_hit = ((fingerprint & mask) == '0);
    end

endmodule

### src/rhcb_ctrl.sv
// ----------------------------------------------------------------------------
// rhcb_ctrl
// Configuration, window, hash and position state; decides each chunk end.
// ----------------------------------------------------------------------------
module rhcb_ctrl
    import rhcb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         accept,
    input  logic [7:0]   data_byte,
    output rhcb_result_t result
);

    logic [15:0] min_chunk_reg;
    logic [15:0] max_chunk_reg;
    logic [4:0]  boundary_bits_reg;
    logic [31:0] stream_length_reg;

    logic [HASH_W-1:0]                hash_reg;
    logic [HASH_W-1:0]                hash_next;
    logic [WINDOW_BYTES-1:0][7:0]     window_reg;
    logic [15:0]                      chunk_pos_reg;
    logic [15:0]                      chunk_pos_next;
    logic [31:0]                      stream_pos_reg;
    logic [31:0]                      stream_pos_next;

    logic [16:0]    len;
    logic [31:0]    stream_count;
    logic           hashing;
    logic           content_end;
    logic           max_end;
    logic           stream_end;
    logic           chunk_end;
    rhcb_hash_req_t hash_req;
    rhcb_hash_rsp_t hash_rsp;

    assign hash_req.hash          = hash_reg;
    assign hash_req.newest        = window_reg[WINDOW_BYTES-1];
    assign hash_req.oldest        = window_reg[0];
    assign hash_req.boundary_bits = boundary_bits_reg;

    rhcb_hash u_hash
    (
        .req (hash_req),
        .rsp (hash_rsp)
    );

    always_comb
    begin
        len          = {1'b0, chunk_pos_reg} + 17'd1;
        stream_count = stream_pos_reg + 32'd1;
        hashing      = (len > 17'(WINDOW_BYTES));
        content_end  = hashing && (len >= {1'b0, min_chunk_reg}) && hash_rsp.content_hit;
        max_end      = (len >= {1'b0, max_chunk_reg});
        stream_end   = (stream_count == stream_length_reg);
        chunk_end    = content_end || max_end || stream_end;

        if (chunk_end)
        begin
            hash_next = '0;
        end
        else if (hashing)
        begin
            hash_next = hash_rsp.hash_next;
        end
        else
        begin
            hash_next = hash_reg;
        end

        chunk_pos_next  = chunk_end ? 16'd0 : len[15:0];
        stream_pos_next = stream_end ? 32'd0 : stream_count;

        result.out_byte     = data_byte;
        result.chunk_end    = chunk_end;
        result.chunk_length = len[15:0];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_chunk_reg     <= MIN_CHUNK_RST;
            max_chunk_reg     <= MAX_CHUNK_RST;
            boundary_bits_reg <= BOUNDARY_BITS_RST;
            stream_length_reg <= STREAM_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_CHUNK:     min_chunk_reg     <= cfg_data[15:0];
                REG_MAX_CHUNK:     max_chunk_reg     <= cfg_data[15:0];
                REG_BOUNDARY_BITS: boundary_bits_reg <= cfg_data[4:0];
                REG_STREAM_LENGTH: stream_length_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Hash and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg       <= '0;
            chunk_pos_reg  <= '0;
            stream_pos_reg <= '0;
        end
        else if (accept)
        begin
            hash_reg       <= hash_next;
            chunk_pos_reg  <= chunk_pos_next;
            stream_pos_reg <= stream_pos_next;
        end
    end

    // Shift the window on every byte; a chunk refills it before it is used
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg <= {data_byte, window_reg[WINDOW_BYTES-1:1]};
        end
    end

endmodule

### src/rhcb_out_buf.sv
// ----------------------------------------------------------------------------
// rhcb_out_buf
// Two-entry result buffer; splits the input and output handshakes.
// ----------------------------------------------------------------------------
module rhcb_out_buf
    import rhcb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  rhcb_result_t push_data,
    output logic         can_push,
    output logic         pop_valid,
    input  logic         pop_ready,
    output rhcb_result_t pop_data
);

    rhcb_result_t entry_reg [2];
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic         pop;

    assign can_push  = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/rhcb_checker.sv
// ----------------------------------------------------------------------------
// rhcb_props
// Port-level checks on chunk lengths and the output handshake.
// ----------------------------------------------------------------------------
module rhcb_props
    import rhcb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [31:0] cfg_data,
    input logic        out_valid,
    input logic        out_ready,
    input logic        chunk_end,
    input logic [15:0] chunk_length
);

    logic [15:0] max_chunk_reg;
    logic [15:0] last_len_reg;
    logic        last_end_reg;
    logic        out_take;
    logic [15:0] expect_len;

    assign out_take   = out_valid && out_ready;
    assign expect_len = last_end_reg ? 16'd1 : last_len_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chunk_reg <= MAX_CHUNK_RST;
            last_len_reg  <= 16'd0;
            last_end_reg  <= 1'b1;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_MAX_CHUNK))
            begin
                max_chunk_reg <= cfg_data[15:0];
            end
            if (out_take)
            begin
                last_len_reg <= chunk_length;
                last_end_reg <= chunk_end;
            end
        end
    end

    a_len_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (chunk_length != 16'd0))
        else $error("chunk length of zero");

    a_len_sequence : assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (chunk_length == expect_len))
        else $error("chunk length does not follow the previous byte");

    a_max_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && (chunk_length >= max_chunk_reg)) |-> chunk_end)
        else $error("chunk not ended at maximum length");

    a_valid_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output valid dropped while stalled");

endmodule

bind rolling_hash_chunk_boundary rhcb_props u_rhcb_props
(
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (data_out.valid),
    .out_ready    (data_out.ready),
    .chunk_end    (data_out.chunk_end),
    .chunk_length (data_out.chunk_length)
);
